[rtl/sal_pkg.sv]
// ----------------------------------------------------------------------------
// sal_pkg
// Shared types and constants for the shelf atlas allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package sal_pkg;

  localparam int COL_W  = 13;
  localparam int ROW_W  = 16;
  localparam int REQ_W  = 16;
  localparam int SUM_W  = 32;
  localparam int CFG_W  = 16;
  localparam int CIDX_W = 1;

  localparam logic [COL_W-1:0] MIN_FREE_COLS = 13'd4;
  localparam logic [COL_W-1:0] AW_RESET      = 13'd2048;
  localparam logic [ROW_W-1:0] AH_RESET      = 16'd2048;

  localparam logic [CIDX_W-1:0] CFG_ATLAS_WIDTH  = 1'b0;
  localparam logic [CIDX_W-1:0] CFG_ATLAS_HEIGHT = 1'b1;

  typedef struct packed {
    logic [REQ_W-1:0] req_width;
    logic [REQ_W-1:0] req_height;
  } sal_req_t;

  typedef struct packed {
    logic [COL_W-1:0] pos_x;
    logic [ROW_W-1:0] pos_y;
    logic             past_height;
    logic [SUM_W-1:0] allocated_total;
    logic [SUM_W-1:0] used_space;
  } sal_res_t;

  typedef struct packed {
    logic fits;
    logic short_left;
    logic roomy;
    logic lacks;
  } sal_fit_t;

  typedef struct packed {
    logic drop;
    logic push;
    logic upd;
  } sal_fr_op_t;

endpackage

`default_nettype wire

[rtl/sal_fit.sv]
// ----------------------------------------------------------------------------
// sal_fit
// Shared space compare: free columns right of a column against a width.
// ----------------------------------------------------------------------------
`default_nettype none

module sal_fit (
  input  wire logic [sal_pkg::COL_W-1:0] aw,
  input  wire logic [sal_pkg::COL_W-1:0] col,
  input  wire logic [sal_pkg::COL_W-1:0] w,
  output sal_pkg::sal_fit_t              fit
);
  import sal_pkg::*;

  logic [COL_W-1:0] space;
  logic [COL_W-1:0] left;

  assign space = (aw > col) ? (aw - col) : '0;
  assign left  = space - w;

  assign fit.fits       = space > w;
  assign fit.short_left = left < MIN_FREE_COLS;
  assign fit.roomy      = space > MIN_FREE_COLS;
  assign fit.lacks      = space < w;

endmodule

`default_nettype wire

[rtl/sal_mul.sv]
// ----------------------------------------------------------------------------
// sal_mul
// Shared 16 x 16 multiplier with registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module sal_mul (
  input  wire logic        clk,
  input  wire logic [15:0] a,
  input  wire logic [15:0] b,
  output logic      [31:0] prod_r
);
  import sal_pkg::*;

  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

endmodule

`default_nettype wire

[rtl/sal_free_rows.sv]
// ----------------------------------------------------------------------------
// sal_free_rows
// Remembered partly used rows, oldest first, with update, drop and append.
// ----------------------------------------------------------------------------
`default_nettype none

module sal_free_rows #(
  parameter  int FREE_ROWS = 4,
  localparam int IW = (FREE_ROWS > 1) ? $clog2(FREE_ROWS) : 1,
  localparam int CW = $clog2(FREE_ROWS + 1)
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire sal_pkg::sal_fr_op_t       op,
  input  wire logic [IW-1:0]             idx,
  input  wire logic [sal_pkg::COL_W-1:0] upd_x,
  input  wire logic [sal_pkg::COL_W-1:0] push_x,
  input  wire logic [sal_pkg::ROW_W-1:0] push_y,
  output logic      [sal_pkg::COL_W-1:0] rd_x,
  output logic      [sal_pkg::ROW_W-1:0] rd_y,
  output logic      [CW-1:0]             count
);
  import sal_pkg::*;

  logic [COL_W-1:0] row_x_r [FREE_ROWS];
  logic [ROW_W-1:0] row_y_r [FREE_ROWS];
  logic [CW-1:0]    count_r;
  logic [CW-1:0]    count_nxt;
  logic [CW-1:0]    wpos;

  assign wpos      = count_r - CW'(op.drop);
  assign count_nxt = wpos + CW'(op.push);
  assign count     = count_r;
  assign rd_x      = row_x_r[idx];
  assign rd_y      = row_y_r[idx];

  for (genvar k = 0; k < FREE_ROWS; k++) begin : g_row
    logic [COL_W-1:0] sh_x;
    logic [ROW_W-1:0] sh_y;
    logic [COL_W-1:0] x_nxt;
    logic [ROW_W-1:0] y_nxt;

    if (k < FREE_ROWS - 1) begin : g_sh
      assign sh_x = row_x_r[k+1];
      assign sh_y = row_y_r[k+1];
    end else begin : g_top
      assign sh_x = row_x_r[k];
      assign sh_y = row_y_r[k];
    end

    always_comb begin
      x_nxt = row_x_r[k];
      y_nxt = row_y_r[k];
      if (op.drop && (IW'(k) >= idx)) begin
        x_nxt = sh_x;
        y_nxt = sh_y;
      end
      if (op.upd && (IW'(k) == idx)) begin
        x_nxt = upd_x;
      end
      if (op.push && (CW'(k) == wpos)) begin
        x_nxt = push_x;
        y_nxt = push_y;
      end
    end

    always_ff @(posedge clk) begin
      row_x_r[k] <= x_nxt;
      row_y_r[k] <= y_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/shelf_atlas_allocator.sv]
// ----------------------------------------------------------------------------
// shelf_atlas_allocator
// Shelf packing allocator: first-fit over remembered rows, then the cursor.
//
//   port group   dir  handshake           word
//   in_*         in   in_valid/in_stall   sal_req_t (req_width, req_height)
//   out_*        out  out_valid/out_stall sal_res_t (position, totals, flag)
//   cfg_*        in   cfg_we              index 0 atlas_width, 1 atlas_height
//
// after the accept the block scans one remembered row per cycle through the
// shared fit compare, then the cursor, and takes two products from the shared
// multiplier for the used space before the result is loaded.
// the next word is taken the cycle after the result is loaded.
// synchronous active-low reset clears cursor, totals and row count and
// restores the config defaults.
// a stalled result holds in the output register; the block waits in its last
// step until that register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module shelf_atlas_allocator #(
  parameter int ROW_HEIGHT = 16,
  parameter int FREE_ROWS  = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire sal_pkg::sal_req_t          in_data,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output sal_pkg::sal_res_t               out_data,
  input  wire logic                       cfg_we,
  input  wire logic [sal_pkg::CIDX_W-1:0] cfg_idx,
  input  wire logic [sal_pkg::CFG_W-1:0]  cfg_wdata
);
  import sal_pkg::*;

  localparam int IW = (FREE_ROWS > 1) ? $clog2(FREE_ROWS) : 1;
  localparam int CW = $clog2(FREE_ROWS + 1);
  localparam logic [15:0] RH = 16'(ROW_HEIGHT);
  localparam logic [CW-1:0] FULL = CW'(FREE_ROWS);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_U1   = 5'b00100,
    S_U2   = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t           state_r, state_nxt;
  logic [COL_W-1:0] aw_r;
  logic [ROW_W-1:0] ah_r;
  logic [COL_W-1:0] cursor_x_r, cursor_x_nxt;
  logic [ROW_W-1:0] cursor_y_r, cursor_y_nxt;
  logic [SUM_W-1:0] alloc_sum_r, alloc_sum_nxt;
  logic [COL_W-1:0] w_r, w_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;
  logic [COL_W-1:0] px_r, px_nxt;
  logic [ROW_W-1:0] py_r, py_nxt;
  logic [SUM_W-1:0] acc_r;
  logic             out_valid_r, out_valid_nxt;
  sal_res_t         out_data_r;

  logic             in_acc;
  logic             load;
  logic [COL_W-1:0] w_in;
  logic [15:0]      mul_a, mul_b;
  logic [31:0]      prod_r;
  logic [COL_W-1:0] fit_col;
  sal_fit_t         fit;
  sal_fr_op_t       fr_op;
  logic [IW-1:0]    fr_idx;
  logic [COL_W-1:0] fr_upd_x;
  logic [COL_W-1:0] fr_rd_x;
  logic [ROW_W-1:0] fr_rd_y;
  logic [CW-1:0]    fr_count;
  logic             at_end;
  logic [COL_W-1:0] cx_base;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign load      = (state_r == S_FIN) && (!out_valid_r || !out_stall);

  assign w_in   = (in_data.req_width < REQ_W'(aw_r)) ? in_data.req_width[COL_W-1:0] : aw_r;
  assign at_end = (idx_r == fr_count);

  sal_mul u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  assign fit_col = at_end ? cursor_x_r : fr_rd_x;

  sal_fit u_fit (
    .aw  (aw_r),
    .col (fit_col),
    .w   (w_r),
    .fit (fit)
  );

  sal_free_rows #(
    .FREE_ROWS (FREE_ROWS)
  ) u_rows (
    .clk    (clk),
    .rst_n  (rst_n),
    .op     (fr_op),
    .idx    (fr_idx),
    .upd_x  (fr_upd_x),
    .push_x (cursor_x_r),
    .push_y (cursor_y_r),
    .rd_x   (fr_rd_x),
    .rd_y   (fr_rd_y),
    .count  (fr_count)
  );

  assign fr_upd_x = fr_rd_x + w_r;
  assign cx_base  = fit.lacks ? '0 : cursor_x_r;

  always_comb begin
    case (state_r)
      S_IDLE: begin
        mul_a = 16'(w_in);
        mul_b = in_data.req_height;
      end
      S_U1: begin
        mul_a = cursor_y_r;
        mul_b = 16'(aw_r);
      end
      default: begin
        mul_a = 16'(cursor_x_r);
        mul_b = RH;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    cursor_x_nxt  = cursor_x_r;
    cursor_y_nxt  = cursor_y_r;
    alloc_sum_nxt = alloc_sum_r;
    w_nxt         = w_r;
    idx_nxt       = idx_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    fr_op         = '0;
    fr_idx        = idx_r[IW-1:0];
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          w_nxt     = w_in;
          idx_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (idx_r == '0) begin
          alloc_sum_nxt = alloc_sum_r + prod_r;
        end
        if (at_end) begin
          // no remembered row fits: place at the cursor, on a new row if the cursor row lacks space
          fr_idx        = '0;
          fr_op.drop    = (fr_count >= FULL);
          fr_op.push    = fit.lacks && fit.roomy;
          cursor_y_nxt  = fit.lacks ? (cursor_y_r + RH) : cursor_y_r;
          px_nxt        = cx_base;
          py_nxt        = cursor_y_nxt;
          cursor_x_nxt  = cx_base + w_r;
          state_nxt     = S_U1;
        end else if (fit.fits) begin
          fr_op.drop = fit.short_left;
          fr_op.upd  = !fit.short_left;
          px_nxt     = fr_rd_x;
          py_nxt     = fr_rd_y;
          state_nxt  = S_U1;
        end else begin
          idx_nxt = idx_r + CW'(1);
        end
      end
      S_U1: begin
        state_nxt = S_U2;
      end
      S_U2: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      aw_r        <= AW_RESET;
      ah_r        <= AH_RESET;
      cursor_x_r  <= '0;
      cursor_y_r  <= '0;
      alloc_sum_r <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_x_r  <= cursor_x_nxt;
      cursor_y_r  <= cursor_y_nxt;
      alloc_sum_r <= alloc_sum_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          CFG_ATLAS_WIDTH:  aw_r <= cfg_wdata[COL_W-1:0];
          CFG_ATLAS_HEIGHT: ah_r <= cfg_wdata[ROW_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    w_r  <= w_nxt;
    px_r <= px_nxt;
    py_r <= py_nxt;
    if (state_r == S_U2) begin
      acc_r <= prod_r;
    end
    if (load) begin
      out_data_r.pos_x           <= px_r;
      out_data_r.pos_y           <= py_r;
      out_data_r.past_height     <= (py_r >= ah_r);
      out_data_r.allocated_total <= alloc_sum_r;
      out_data_r.used_space      <= acc_r + prod_r;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fr_count <= FULL)
    else $error("free row count beyond capacity");

  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_SCAN))
    else $error("accepted word did not start the scan");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result raised outside the final step");

  a_cursor_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_SCAN) |=> $stable(cursor_x_r) && $stable(cursor_y_r))
    else $error("cursor moved outside the scan");
`endif

endmodule

`default_nettype wire
